// File: rtl/jlsc_pkg.sv
// Shared types and constants for the jerk-limited S-curve ramp.
package jlsc_pkg;

  localparam int unsigned QFRAC   = 24;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ULIM_W  = 31;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned MDIG_W  = 4;
  localparam int unsigned MPROD_W = 2 * DATA_W;
  localparam int unsigned MRES_W  = MPROD_W - 2 - QFRAC + 1;

  localparam logic [CIDX_W-1:0] REG_ACCEL_LIMIT_UP   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ACCEL_LIMIT_DOWN = 3'd1;
  localparam logic [CIDX_W-1:0] REG_JERK_UP          = 3'd2;
  localparam logic [CIDX_W-1:0] REG_JERK_DOWN        = 3'd3;
  localparam logic [CIDX_W-1:0] REG_TIME_STEP        = 3'd4;

  localparam logic [ULIM_W-1:0] RST_ACCEL_LIMIT_UP   = 31'd16777216;
  localparam logic [DATA_W-1:0] RST_ACCEL_LIMIT_DOWN = 32'hFE666666;
  localparam logic [ULIM_W-1:0] RST_JERK_UP          = 31'd268435456;
  localparam logic [ULIM_W-1:0] RST_JERK_DOWN        = 31'd671088640;
  localparam logic [ULIM_W-1:0] RST_TIME_STEP        = 31'd83886;

  localparam logic signed [DATA_W:0] SNAP_TOL = 33'sd50332;

  typedef struct packed {
    logic [ULIM_W-1:0] accel_limit_up;
    logic [DATA_W-1:0] accel_limit_down;
    logic [ULIM_W-1:0] jerk_up;
    logic [ULIM_W-1:0] jerk_down;
    logic [ULIM_W-1:0] time_step;
  } cfg_t;

endpackage

// File: rtl/jlsc_cfg_regs.sv
// Configuration register bank with reset presets and state-clear strobe.
module jlsc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [jlsc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [jlsc_pkg::DATA_W-1:0] cfg_data,
  output jlsc_pkg::cfg_t              cfg,
  output logic                        cfg_clear
);
  import jlsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic hit;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_ACCEL_LIMIT_UP: begin
          cfg_nxt.accel_limit_up = cfg_data[ULIM_W-1:0];
          hit = 1'b1;
        end
        REG_ACCEL_LIMIT_DOWN: begin
          cfg_nxt.accel_limit_down = cfg_data;
          hit = 1'b1;
        end
        REG_JERK_UP: begin
          cfg_nxt.jerk_up = cfg_data[ULIM_W-1:0];
          hit = 1'b1;
        end
        REG_JERK_DOWN: begin
          cfg_nxt.jerk_down = cfg_data[ULIM_W-1:0];
          hit = 1'b1;
        end
        REG_TIME_STEP: begin
          cfg_nxt.time_step = cfg_data[ULIM_W-1:0];
          hit = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_limit_up   <= RST_ACCEL_LIMIT_UP;
      cfg_r.accel_limit_down <= RST_ACCEL_LIMIT_DOWN;
      cfg_r.jerk_up          <= RST_JERK_UP;
      cfg_r.jerk_down        <= RST_JERK_DOWN;
      cfg_r.time_step        <= RST_TIME_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg       = cfg_r;
  assign cfg_clear = hit;

endmodule

// File: rtl/jlsc_serial_mul.sv
// Radix-16 digit-serial unsigned multiplier with Q8.24 round-half-up scaling.
module jlsc_serial_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [jlsc_pkg::DATA_W-1:0] mcand,
  input  logic [jlsc_pkg::ULIM_W-1:0] mplier,
  output logic                        done,
  output logic [jlsc_pkg::MRES_W-1:0] result
);
  import jlsc_pkg::*;

  localparam int unsigned NDIG  = DATA_W / MDIG_W;
  localparam int unsigned CNT_W = $clog2(NDIG);
  localparam int unsigned PART_W = DATA_W + MDIG_W;

  logic [DATA_W-1:0]  mcand_r, mcand_nxt;
  logic [MPROD_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [PART_W-1:0]  part;
  logic [PART_W-1:0]  upper;

  always_comb begin
    part      = PART_W'(mcand_r) * PART_W'(prod_r[MDIG_W-1:0]);
    upper     = PART_W'(prod_r[MPROD_W-1:DATA_W]) + part;
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    if (start) begin
      mcand_nxt = mcand;
      prod_nxt  = {{DATA_W{1'b0}}, 1'b0, mplier};
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
      done_nxt  = 1'b0;
    end else if (busy_r) begin
      prod_nxt = {upper, prod_r[DATA_W-1:MDIG_W]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NDIG - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    prod_r  <= prod_nxt;
  end

  assign done   = done_r;
  assign result = prod_r[MPROD_W-2:QFRAC] + MRES_W'(prod_r[QFRAC-1]);

endmodule

// File: rtl/jerk_limited_scurve_ramp_unit.sv
// Top level of the jerk-limited S-curve ramp: control sequencer and datapath.
// Each target word produces one result word: the new Q8.24 setpoint and the
// tracking error against the previous setpoint. A target within the snap
// tolerance of the current setpoint skips the multiplier and goes from the
// check step straight to the completion step. A full update runs two
// dependent products (jerk * time step, then acceleration * time step)
// through one shared radix-16 digit-serial multiplier, with compare and
// saturate steps around them. The next target is accepted the cycle after
// the result is registered, while that result still waits on out_ready.
// Any write to a defined register index clears the setpoint, acceleration
// and direction state; writes to the spare indexes do not.
module jerk_limited_scurve_ramp_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [jlsc_pkg::DATA_W-1:0] in_target,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [jlsc_pkg::DATA_W-1:0] out_setpoint,
  output logic [jlsc_pkg::DATA_W-1:0] out_tracking_error,
  input  logic                        cfg_we,
  input  logic [jlsc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [jlsc_pkg::DATA_W-1:0] cfg_data
);
  import jlsc_pkg::*;

  localparam int unsigned WW = DATA_W + 9;
  localparam int unsigned BW = DATA_W + 2;
  localparam int unsigned SW = MRES_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_JS, S_ACC, S_STEP, S_BOUND, S_SNAP, S_DONE
  } state_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [WW-1:0] v);
    if (v > $signed(WW'(32'sh7FFFFFFF)))       sat32 = 32'h7FFFFFFF;
    else if (v < -$signed(WW'(33'sh080000000))) sat32 = 32'h80000000;
    else                                          sat32 = v[DATA_W-1:0];
  endfunction

  cfg_t cfg;
  logic cfg_clear;
  logic mul_start;
  logic [DATA_W-1:0] mul_a;
  logic mul_done;
  logic [MRES_W-1:0] mul_res;

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              last_dir_r, last_dir_nxt;
  logic [DATA_W-1:0] tgt_r, tgt_nxt;
  logic [DATA_W:0]   diff_r, diff_nxt;
  logic [DATA_W-1:0] err_r, err_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [MRES_W-1:0] js_r, js_nxt;
  logic              neg_r, neg_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [WW-1:0]     lo_r, lo_nxt;
  logic [WW-1:0]     hi_r, hi_nxt;
  logic [WW-1:0]     sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_sp_r, out_sp_nxt;
  logic [DATA_W-1:0] out_err_r, out_err_nxt;

  logic              near_tgt;
  logic              cur_neg;
  logic              cur_zero;
  logic              dir;
  logic              add;
  logic [BW-1:0]     base;
  logic [BW-1:0]     bound;
  logic [WW-1:0]     aw;
  logic [WW-1:0]     bw;
  logic              cond;
  logic [WW-1:0]     anew;
  logic [DATA_W-1:0] asat;
  logic [WW-1:0]     d1;
  logic [WW-1:0]     d2;
  logic [WW-1:0]     ao;
  logic              slot_free;

  jlsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_clear (cfg_clear)
  );

  jlsc_serial_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (cfg.time_step),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    cur_neg  = cur_r[DATA_W-1];
    cur_zero = (cur_r == '0);
    near_tgt = ($signed(diff_r) < SNAP_TOL) && ($signed(diff_r) > -SNAP_TOL);
    // diff is nonzero here whenever it is used
    dir      = cur_zero || ((!cur_neg) == (!diff_r[DATA_W]));

    add   = last_dir_r ^ cur_neg;
    base  = last_dir_r ? {3'b000, cfg.accel_limit_up}
                       : {{2{cfg.accel_limit_down[DATA_W-1]}}, cfg.accel_limit_down};
    bound = cur_neg ? (~base + 1'b1) : base;
    aw    = {{(WW-DATA_W){acc_r[DATA_W-1]}}, acc_r};
    bw    = {{(WW-BW){bound[BW-1]}}, bound};
    cond  = add ? ($signed(aw) < $signed(bw)) : ($signed(aw) > $signed(bw));
    if (cond) anew = add ? aw + WW'(js_r) : aw - WW'(js_r);
    else      anew = bw;
    asat  = sat32($signed(anew));

    d1  = {{(WW-DATA_W){tgt_r[DATA_W-1]}}, tgt_r} - {{(WW-SW){step_r[SW-1]}}, step_r};
    d2  = {{(WW-DATA_W){tgt_r[DATA_W-1]}}, tgt_r} + {{(WW-SW){step_r[SW-1]}}, step_r};
    ao  = {{(WW-DATA_W){1'b0}}, (cur_neg ? (~cur_r + 1'b1) : cur_r)};
    slot_free = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    acc_nxt      = acc_r;
    last_dir_nxt = last_dir_r;
    tgt_nxt      = tgt_r;
    diff_nxt     = diff_r;
    err_nxt      = err_r;
    res_nxt      = res_r;
    js_nxt       = js_r;
    neg_nxt      = neg_r;
    step_nxt     = step_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    sum_nxt      = sum_r;
    out_sp_nxt   = out_sp_r;
    out_err_nxt  = out_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mul_start    = 1'b0;
    mul_a        = {1'b0, cfg.jerk_up};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tgt_nxt   = in_target;
          diff_nxt  = {in_target[DATA_W-1], in_target} - {cur_r[DATA_W-1], cur_r};
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        err_nxt = sat32($signed({{(WW-DATA_W-1){diff_r[DATA_W]}}, diff_r}));
        if (near_tgt) begin
          res_nxt   = tgt_r;
          state_nxt = S_DONE;
        end else begin
          if (dir != last_dir_r) begin
            last_dir_nxt = dir;
            acc_nxt      = '0;
          end
          mul_start = 1'b1;
          mul_a     = dir ? {1'b0, cfg.jerk_up} : {1'b0, cfg.jerk_down};
          state_nxt = S_JS;
        end
      end
      S_JS: begin
        if (mul_done) begin
          js_nxt    = mul_res;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        acc_nxt   = asat;
        neg_nxt   = asat[DATA_W-1];
        mul_start = 1'b1;
        mul_a     = asat[DATA_W-1] ? (~asat + 1'b1) : asat;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (mul_done) begin
          step_nxt  = neg_r ? (~{1'b0, mul_res} + 1'b1) : {1'b0, mul_res};
          state_nxt = S_BOUND;
        end
      end
      S_BOUND: begin
        lo_nxt    = d1[WW-1] ? (~d1 + 1'b1) : d1;
        hi_nxt    = d2[WW-1] ? (~d2 + 1'b1) : d2;
        sum_nxt   = {{(WW-DATA_W){cur_r[DATA_W-1]}}, cur_r}
                  + {{(WW-SW){step_r[SW-1]}}, step_r};
        state_nxt = S_SNAP;
      end
      S_SNAP: begin
        res_nxt   = (ao >= lo_r && ao <= hi_r) ? tgt_r : sat32($signed(sum_r));
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cur_nxt       = res_r;
          out_sp_nxt    = res_r;
          out_err_nxt   = err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_clear) begin
      cur_nxt      = '0;
      acc_nxt      = '0;
      last_dir_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      acc_r       <= '0;
      last_dir_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      acc_r       <= acc_nxt;
      last_dir_r  <= last_dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tgt_r     <= tgt_nxt;
    diff_r    <= diff_nxt;
    err_r     <= err_nxt;
    res_r     <= res_nxt;
    js_r      <= js_nxt;
    neg_r     <= neg_nxt;
    step_r    <= step_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    sum_r     <= sum_nxt;
    out_sp_r  <= out_sp_nxt;
    out_err_r <= out_err_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_setpoint       = out_sp_r;
  assign out_tracking_error = out_err_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in flight");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result word raised outside completion step");

  a_near_snap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK && near_tgt |=> state_r == S_DONE && res_r == tgt_r)
    else $error("near-target word did not snap to target");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> cur_r == '0 && acc_r == '0 && !last_dir_r)
    else $error("register write did not clear ramp state");

endmodule

// File: tb/tb_jerk_limited_scurve_ramp_unit.sv
// Self-checking testbench for the jerk-limited S-curve ramp unit.
`timescale 1ns / 1ps

module tb_jerk_limited_scurve_ramp_unit;
  import jlsc_pkg::*;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam longint SNAP_TOL_Q     = 50332;
  localparam int     PHASE_WORDS    = 96;
  localparam logic [CIDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum {PROFILE_LINE, PROFILE_ANGLE, PROFILE_FASTEST, PROFILE_STILL} profile_t;

  typedef struct {
    logic [DATA_W-1:0] setpoint;
    logic [DATA_W-1:0] tracking_error;
  } ramp_word_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [DATA_W-1:0] in_target;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_setpoint;
  logic [DATA_W-1:0] out_tracking_error;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // ramp model: profile and state
  longint lim_up  = longint'(RST_ACCEL_LIMIT_UP);
  longint lim_dn  = longint'($signed(RST_ACCEL_LIMIT_DOWN));
  longint jerk_up = longint'(RST_JERK_UP);
  longint jerk_dn = longint'(RST_JERK_DOWN);
  longint dt      = longint'(RST_TIME_STEP);
  longint pos     = 0;
  longint acc     = 0;
  bit     dir_up  = 1'b0;

  ramp_word_t ramp_words_due[$];
  int         mismatches    = 0;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         idle_cycles   = 0;

  jerk_limited_scurve_ramp_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_target          (in_target),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_setpoint       (out_setpoint),
    .out_tracking_error (out_tracking_error),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q8.24 product, round half away from zero
  function automatic longint qprod(longint a, longint b);
    bit        neg;
    bit [63:0] m;
    neg = (a < 0) != (b < 0);
    m = mag(a) * mag(b);
    m = (m + 64'h80_0000) >> QFRAC;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  task automatic apply_reg(input logic [CIDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    case (idx)
      REG_ACCEL_LIMIT_UP:   lim_up  = longint'(d[ULIM_W-1:0]);
      REG_ACCEL_LIMIT_DOWN: lim_dn  = longint'($signed(d));
      REG_JERK_UP:          jerk_up = longint'(d[ULIM_W-1:0]);
      REG_JERK_DOWN:        jerk_dn = longint'(d[ULIM_W-1:0]);
      REG_TIME_STEP:        dt      = longint'(d[ULIM_W-1:0]);
      default:              return;
    endcase
    pos    = 0;
    acc    = 0;
    dir_up = 1'b0;
  endtask

  task automatic advance_ramp(input logic [DATA_W-1:0] tgt_bits, output ramp_word_t w);
    longint t, diff, a, js, step, lo, hi, ao;
    bit     up;
    t    = longint'($signed(tgt_bits));
    diff = t - pos;
    a    = acc;
    w.tracking_error = DATA_W'(sat32(diff));
    if (mag(diff) < SNAP_TOL_Q) begin
      pos = t;
      w.setpoint = tgt_bits;
      return;
    end
    up = (pos == 0) || ((pos > 0) == (diff > 0));
    if (up != dir_up) begin
      dir_up = up;
      a = 0;
    end
    if (up) begin
      js = qprod(jerk_up, dt);
      if (pos >= 0) begin
        if (a < lim_up) a += js; else a = lim_up;
      end else begin
        if (a > -lim_up) a -= js; else a = -lim_up;
      end
    end else begin
      js = qprod(jerk_dn, dt);
      if (pos >= 0) begin
        if (a > lim_dn) a -= js; else a = lim_dn;
      end else begin
        if (a < -lim_dn) a += js; else a = -lim_dn;
      end
    end
    a    = sat32(a);
    acc  = a;
    step = qprod(a, dt);
    ao   = mag(pos);
    lo   = mag(t - step);
    hi   = mag(t + step);
    if (ao >= lo && ao <= hi) pos = t;
    else pos = sat32(pos + step);
    w.setpoint = pos[DATA_W-1:0];
  endtask

  task automatic send_target(input logic [DATA_W-1:0] tgt);
    ramp_word_t w;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_target <= tgt;
    do @(posedge clk); while (!in_ready);
    advance_ramp(tgt, w);
    ramp_words_due.push_back(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (ramp_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_we high; caller lowers it after the last write
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    apply_reg(idx, d);
  endtask

  task automatic program_profile(input logic [DATA_W-1:0] lu, ld, ju, jd, ts);
    wait_idle();
    write_reg(REG_ACCEL_LIMIT_UP, lu);
    write_reg(REG_ACCEL_LIMIT_DOWN, ld);
    write_reg(REG_JERK_UP, ju);
    write_reg(REG_JERK_DOWN, jd);
    write_reg(REG_TIME_STEP, ts);
    cfg_we <= 1'b0;
  endtask

  task automatic program_preset(input profile_t p);
    case (p)
      PROFILE_LINE:    program_profile(32'(RST_ACCEL_LIMIT_UP), RST_ACCEL_LIMIT_DOWN,
                                       32'(RST_JERK_UP), 32'(RST_JERK_DOWN),
                                       32'(RST_TIME_STEP));
      PROFILE_ANGLE:   program_profile(32'd20132659, -32'sd23488102, 32'd402653184,
                                       32'd671088640, 32'd83886);
      PROFILE_FASTEST: program_profile(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF);
      default:         program_profile(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    endcase
  endtask

  task automatic program_random_profile();
    logic [DATA_W-1:0] ld;
    if ($urandom_range(0, 3) == 0) ld = $urandom;
    else ld = -($urandom >> $urandom_range(0, 12));
    program_profile($urandom >> $urandom_range(0, 10), ld,
                    $urandom >> $urandom_range(0, 10), $urandom >> $urandom_range(0, 10),
                    $urandom >> $urandom_range(0, 16));
  endtask

  // held targets let the ramp converge; the rest is steps, flips and noise
  task automatic test_trajectories(input int n_items);
    int                sent, hold, kind;
    logic [DATA_W-1:0] tgt;
    sent = 0;
    tgt  = '0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      hold = $urandom_range(1, 40);
      if (kind < 40) begin
        tgt = $signed($urandom) >>> $urandom_range(0, 30);
      end else if (kind < 55) begin
        tgt = 32'(pos + longint'($urandom_range(0, 32'(4 * SNAP_TOL_Q))) - 2 * SNAP_TOL_Q);
      end else if (kind < 65) begin
        case ($urandom_range(0, 4))
          0:       tgt = 32'h7FFF_FFFF;
          1:       tgt = 32'h8000_0000;
          2:       tgt = '0;
          3:       tgt = 32'd1;
          default: tgt = '1;
        endcase
      end else if (kind < 80) begin
        tgt = -tgt;
      end else begin
        tgt  = $urandom;
        hold = 1;
      end
      for (int i = 0; i < hold && sent < n_items; i++) begin
        send_target(tgt);
        sent++;
      end
    end
  endtask

  task automatic test_snap_and_direction();
    send_target(32'd0);
    send_target(32'd50331);
    send_target(32'd0);
    send_target(32'd50332);
    send_target(-32'sd50332);
    send_target(-32'sd50332);
    send_target(32'h0100_0000);
    send_target(32'h7FFF_FFFF);
    send_target(32'h8000_0000);
  endtask

  task automatic test_accel_clamp();
    program_profile(32'h0010_0000, -32'sd1677722, 32'(RST_JERK_UP),
                    32'(RST_JERK_DOWN), 32'(RST_TIME_STEP));
    repeat (4) send_target(32'h0200_0000);
    repeat (3) send_target(32'hFF00_0000);
  endtask

  task automatic test_saturation_extremes();
    program_preset(PROFILE_FASTEST);
    send_target(32'h7FFF_FFFF);
    send_target(32'h8000_0000);
    send_target(32'h7FFF_FFFF);
    send_target(32'h8000_0000);
  endtask

  task automatic test_positive_slowdown_limit();
    program_profile(32'(RST_ACCEL_LIMIT_UP), 32'h0100_0000, 32'(RST_JERK_UP),
                    32'(RST_JERK_DOWN), 32'h0100_0000);
    repeat (2) send_target(32'h0400_0000);
    repeat (2) send_target(32'hFC00_0000);
  endtask

  // spare indexes must leave profile and state alone
  task automatic test_spare_index();
    program_preset(PROFILE_LINE);
    repeat (2) send_target(32'h0080_0000);
    wait_idle();
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) write_reg(CIDX_W'(i), $urandom);
    cfg_we <= 1'b0;
    repeat (2) send_target(32'h0080_0000);
  endtask

  task automatic test_idle_phase(input int send_pct, input int stall, input profile_t p);
    send_idle_pct = send_pct;
    stall_pct     = stall;
    for (int k = 0; k < 3; k++) begin
      if (k == 0) program_preset(p);
      else program_random_profile();
      test_trajectories(PHASE_WORDS);
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    ramp_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (ramp_words_due.size() == 0) begin
        $display("%0t unexpected word: setpoint %h tracking_error %h",
                 $time, out_setpoint, out_tracking_error);
        mismatches++;
      end else begin
        w = ramp_words_due.pop_front();
        if (out_setpoint !== w.setpoint) begin
          $display("%0t setpoint mismatch: expected %h actual %h",
                   $time, w.setpoint, out_setpoint);
          mismatches++;
        end
        if (out_tracking_error !== w.tracking_error) begin
          $display("%0t tracking_error mismatch: expected %h actual %h",
                   $time, w.tracking_error, out_tracking_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_jerk_limited_scurve_ramp_unit failed");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_target <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_snap_and_direction();
    test_accel_clamp();
    test_saturation_extremes();
    test_positive_slowdown_limit();
    test_spare_index();
    test_idle_phase(0, 0, PROFILE_LINE);
    test_idle_phase(85, 0, PROFILE_ANGLE);
    test_idle_phase(0, 85, PROFILE_FASTEST);
    test_idle_phase(18, 18, PROFILE_STILL);

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && ramp_words_due.size() == 0) begin
      $display("tb_jerk_limited_scurve_ramp_unit passed");
    end else begin
      $display("tb_jerk_limited_scurve_ramp_unit failed");
    end
    $finish;
  end

endmodule
